// ===== rtl/sdq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdq_pkg
// Types, sizes and slot arithmetic shared by the string deque files.
// ---------------------------------------------------------------------------
package sdq_pkg;

  localparam int DEPTH     = 16;
  localparam int MAX_LEN   = 32;
  localparam int BUF_CAP   = 33;

  localparam int SLOT_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int ADDR_W    = $clog2(DEPTH * MAX_LEN);
  localparam int CHAR_W    = 8;
  localparam int BUF_W     = 6;
  localparam int OUT_CNT_W = 5;
  localparam int CMP_W     = ((LEN_W > BUF_W) ? LEN_W : BUF_W) + 1;

  typedef enum logic [1:0] {
    MODE_INS_HEAD = 2'd0,
    MODE_INS_TAIL = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_REVERSE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_CHR,
    ST_TERM
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic [CHAR_W-1:0]  in_char;
    logic               in_last;
    logic               copy_out;
    logic [BUF_W-1:0]   buf_size;
  } in_t;

  typedef struct packed {
    logic                 ok;
    logic [CHAR_W-1:0]    out_char;
    logic                 out_last;
    logic [OUT_CNT_W-1:0] count;
  } out_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] wdata;
  } char_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    logic [LEN_W-1:0]  wdata;
  } len_req_t;

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    slot_dec = (s == '0) ? SLOT_W'(DEPTH - 1) : s - SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                 input logic [CNT_W-1:0]  c);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(s) + SUM_W'(c);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    slot_add = sum[SLOT_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] char_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [LEN_W-1:0]  n);
    char_addr = ADDR_W'(s) * ADDR_W'(MAX_LEN) + ADDR_W'(n);
  endfunction

endpackage

// ===== rtl/sdq_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdq_ram
// Single-port synchronous RAM with registered read data, read data held
// until the next read.
// ---------------------------------------------------------------------------
module sdq_ram #(
  parameter int WIDTH = 8,
  parameter int WORDS = 512,
  parameter int AW    = $clog2(WORDS)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [WORDS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sdq_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdq_ctrl
// Ring pointers, string fill tracking, remove sequencer and output register.
// ---------------------------------------------------------------------------
module sdq_ctrl
  import sdq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o,
  output char_req_t         char_req_o,
  input  logic [CHAR_W-1:0] char_rdata_i,
  output len_req_t          len_req_o,
  input  logic [LEN_W-1:0]  len_rdata_i
);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              rev_q, rev_d;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_data_q, out_data_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [BUF_W-1:0]  lim_q, lim_d;
  logic [LEN_W-1:0]  n_q, n_d;

  logic              out_free;
  logic              in_accept;
  logic              at_front;
  logic [SLOT_W-1:0] ins_slot;
  logic [SLOT_W-1:0] rm_slot;
  logic              not_full;
  logic              has_room;
  logic [LEN_W-1:0]  fill_nx;
  logic              ovf_nx;
  logic [LEN_W-1:0]  len_v;
  logic [LEN_W-1:0]  n_nx;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign at_front = (in_data_i.mode == MODE_INS_HEAD) ^ rev_q;
  assign ins_slot = at_front ? slot_dec(front_q) : slot_add(front_q, count_q);
  assign rm_slot  = rev_q ? slot_add(front_q, count_q - CNT_W'(1)) : front_q;
  assign not_full = count_q < CNT_W'(DEPTH);
  assign has_room = fill_q < LEN_W'(MAX_LEN);
  assign fill_nx  = has_room ? fill_q + LEN_W'(1) : fill_q;
  assign ovf_nx   = ovf_q || !has_room;
  assign len_v    = (len_rdata_i > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_rdata_i;
  assign n_nx     = n_q + LEN_W'(1);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    rev_d       = rev_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    slot_d      = slot_q;
    len_d       = len_q;
    lim_d       = lim_q;
    n_d         = n_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    char_req_o  = '0;
    len_req_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_data_i.mode)
            MODE_INS_HEAD, MODE_INS_TAIL: begin
              char_req_o.we    = has_room && not_full;
              char_req_o.addr  = char_addr(ins_slot, fill_q);
              char_req_o.wdata = in_data_i.in_char;
              fill_d           = fill_nx;
              ovf_d            = ovf_nx;
              if (in_data_i.in_last) begin
                fill_d         = '0;
                ovf_d          = 1'b0;
                out_valid_d    = 1'b1;
                out_data_d     = '{ok: 1'b0, out_char: '0, out_last: 1'b1,
                                   count: OUT_CNT_W'(count_q)};
                if (not_full) begin
                  len_req_o.we    = 1'b1;
                  len_req_o.addr  = ins_slot;
                  len_req_o.wdata = fill_nx;
                  if (at_front) begin
                    front_d = ins_slot;
                  end
                  count_d          = count_q + CNT_W'(1);
                  out_data_d.ok    = !ovf_nx;
                  out_data_d.count = OUT_CNT_W'(count_q + CNT_W'(1));
                end
              end
            end
            MODE_REMOVE: begin
              out_valid_d = 1'b1;
              out_data_d  = '{ok: 1'b0, out_char: '0, out_last: 1'b1,
                              count: OUT_CNT_W'(count_q)};
              if (count_q != '0) begin
                slot_d  = rm_slot;
                count_d = count_q - CNT_W'(1);
                if (!rev_q) begin
                  front_d = slot_add(front_q, CNT_W'(1));
                end
                out_data_d.ok    = 1'b1;
                out_data_d.count = OUT_CNT_W'(count_q - CNT_W'(1));
                if (in_data_i.copy_out) begin
                  out_valid_d    = out_valid_q && out_stall_i;
                  out_data_d     = out_data_q;
                  len_req_o.re   = 1'b1;
                  len_req_o.addr = rm_slot;
                  if (in_data_i.buf_size > BUF_W'(BUF_CAP)) begin
                    lim_d = BUF_W'(BUF_CAP);
                  end else if (in_data_i.buf_size == '0) begin
                    lim_d = BUF_W'(1);
                  end else begin
                    lim_d = in_data_i.buf_size;
                  end
                  state_d = ST_LEN;
                end
              end
            end
            MODE_REVERSE: begin
              rev_d       = !rev_q;
              out_valid_d = 1'b1;
              out_data_d  = '{ok: 1'b1, out_char: '0, out_last: 1'b1,
                              count: OUT_CNT_W'(count_q)};
            end
            default: ;
          endcase
        end
      end
      ST_LEN: begin
        len_d = len_v;
        if ((len_v != '0) && (CMP_W'(1) < CMP_W'(lim_q))) begin
          char_req_o.re   = 1'b1;
          char_req_o.addr = char_addr(slot_q, '0);
          n_d             = '0;
          state_d         = ST_CHR;
        end else begin
          state_d = ST_TERM;
        end
      end
      ST_CHR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (char_rdata_i == '0) begin
            out_data_d = '{ok: 1'b1, out_char: '0, out_last: 1'b1,
                           count: OUT_CNT_W'(count_q)};
            state_d    = ST_IDLE;
          end else begin
            out_data_d = '{ok: 1'b1, out_char: char_rdata_i, out_last: 1'b0,
                           count: OUT_CNT_W'(count_q)};
            if ((n_nx < len_q) && (CMP_W'(n_nx) + CMP_W'(1) < CMP_W'(lim_q))) begin
              char_req_o.re   = 1'b1;
              char_req_o.addr = char_addr(slot_q, n_nx);
              n_d             = n_nx;
            end else begin
              state_d = ST_TERM;
            end
          end
        end
      end
      ST_TERM: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{ok: 1'b1, out_char: '0, out_last: 1'b1,
                          count: OUT_CNT_W'(count_q)};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    slot_q     <= slot_d;
    len_q      <= len_d;
    lim_q      <= lim_d;
    n_q        <= n_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/string_deque_with_reverse.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// string_deque_with_reverse
// Deque of byte strings kept in a ring of fixed slots, with reverse.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per item.
// Insert items carry one string byte each and are taken one per cycle while the
// output is not stalled; the byte marked last commits the entry and yields one result in the next cycle.
// Reverse and remove-without-copy items also yield their single result in
// the cycle after the transfer.
// A remove with copy first reads the slot length, then streams the bytes
// from the character RAM at one per cycle while the output is not stalled,
// and ends with a zero terminator. Input stays stalled until the terminator
// is registered.
// Output channel (out_valid_o / out_stall_i / out_data_o): a single output
// register. While the receiver stalls, the result holds, streaming pauses
// and new input is stalled.
// Reset clears the ring pointers, count, direction and fill state; the
// string and length RAMs are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module string_deque_with_reverse
  import sdq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  char_req_t         char_req;
  len_req_t          len_req;
  logic [CHAR_W-1:0] char_rdata;
  logic [LEN_W-1:0]  len_rdata;

  sdq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .char_req_o   (char_req),
    .char_rdata_i (char_rdata),
    .len_req_o    (len_req),
    .len_rdata_i  (len_rdata)
  );

  sdq_ram #(
    .WIDTH (CHAR_W),
    .WORDS (DEPTH * MAX_LEN)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (char_req.we),
    .re_i    (char_req.re),
    .addr_i  (char_req.addr),
    .wdata_i (char_req.wdata),
    .rdata_o (char_rdata)
  );

  sdq_ram #(
    .WIDTH (LEN_W),
    .WORDS (DEPTH)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_req.we),
    .re_i    (len_req.re),
    .addr_i  (len_req.addr),
    .wdata_i (len_req.wdata),
    .rdata_o (len_rdata)
  );

endmodule

// ===== rtl/sdq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdq_checker
// Port-level checks for the string deque, bound to the top level.
// ---------------------------------------------------------------------------
module sdq_checker
  import sdq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.count <= OUT_CNT_W'(DEPTH))
    else $error("count above depth");

  a_back_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result held");

  a_stream_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_last |-> out_data_o.ok && out_data_o.out_char != '0)
    else $error("bad streamed byte");

  a_final_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_last |-> out_data_o.out_char == '0)
    else $error("final result carries a byte");

endmodule

bind string_deque_with_reverse sdq_checker u_sdq_checker (.*);

// ===== dv/string_deque_with_reverse_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// string_deque_with_reverse_test
// Self-checking bench for the string deque with reverse.
// A short directed list followed by random string traffic is queued at time
// zero and sent through the valid/stall input channel with random gaps. Each
// accepted transfer runs through a behavioral deque kept in the bench, and
// every output transfer is checked field by field against the oldest result
// still due. Both channels idle at random, except for one quiet stretch.
// ---------------------------------------------------------------------------
module string_deque_with_reverse_test;
  import sdq_pkg::*;

  localparam int DEPTH_ITEMS = 330;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 64;
  localparam int IDLE_PCT = 37;
  localparam int MAX_REPORTS = 50;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t  deque_ops_queued[$];
  out_t deque_results_due[$];
  int   ops_total;
  int   ops_accepted = 0;
  int   cycle_cnt = 0;
  int   errors = 0;
  logic quiet_stretch;

  // behavioral deque state
  logic [CHAR_W-1:0] char_mem[DEPTH*MAX_LEN];
  bit                char_written[DEPTH*MAX_LEN];
  int                slot_len[DEPTH];
  int                front_slot;
  int                entry_cnt;
  bit                reversed;
  int                fill_len;
  bit                truncated;

  assign quiet_stretch = (ops_accepted >= 150) && (ops_accepted < 240);

  string_deque_with_reverse i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic clear_deque();
    front_slot   = 0;
    entry_cnt    = 0;
    reversed     = 1'b0;
    fill_len     = 0;
    truncated    = 1'b0;
    char_written = '{default: 1'b0};
  endtask

  function automatic int buf_limit(input logic [BUF_W-1:0] bs);
    if (bs > BUF_CAP) return BUF_CAP;
    if (bs == 0) return 1;
    return int'(bs);
  endfunction

  function automatic void queue_result(input bit record, input logic ok,
                                       input logic [CHAR_W-1:0] ch, input logic last);
    out_t r;
    r.ok       = ok;
    r.out_char = ch;
    r.out_last = last;
    r.count    = OUT_CNT_W'(entry_cnt);
    if (record) deque_results_due.push_back(r);
  endfunction

  task automatic apply_to_deque(input in_t op, input bit record);
    int  slot;
    int  len;
    int  lim;
    int  n;
    bit  head_side;
    bit  ok;
    case (op.mode)
      MODE_INS_HEAD, MODE_INS_TAIL: begin
        head_side = (op.mode == MODE_INS_HEAD) != reversed;
        slot = head_side ? (front_slot + DEPTH - 1) % DEPTH : (front_slot + entry_cnt) % DEPTH;
        if (fill_len < MAX_LEN) begin
          if (entry_cnt < DEPTH) begin
            char_mem[slot*MAX_LEN + fill_len]     = op.in_char;
            char_written[slot*MAX_LEN + fill_len] = 1'b1;
          end
          fill_len++;
        end else begin
          truncated = 1'b1;
        end
        if (op.in_last) begin
          ok = 1'b0;
          if (entry_cnt < DEPTH) begin
            slot_len[slot] = fill_len;
            if (head_side) front_slot = slot;
            entry_cnt++;
            ok = !truncated;
          end
          fill_len  = 0;
          truncated = 1'b0;
          queue_result(record, ok, 8'h00, 1'b1);
        end
      end
      MODE_REMOVE: begin
        if (entry_cnt == 0) begin
          queue_result(record, 1'b0, 8'h00, 1'b1);
        end else begin
          if (reversed) begin
            slot = (front_slot + entry_cnt - 1) % DEPTH;
          end else begin
            slot = front_slot;
            front_slot = (front_slot + 1) % DEPTH;
          end
          entry_cnt--;
          n = 0;
          if (op.copy_out) begin
            lim = buf_limit(op.buf_size);
            len = slot_len[slot];
            while (n < len && n + 1 < lim && char_mem[slot*MAX_LEN + n] != 8'h00) begin
              queue_result(record, 1'b1, char_mem[slot*MAX_LEN + n], 1'b0);
              n++;
            end
          end
          queue_result(record, 1'b1, 8'h00, 1'b1);
        end
      end
      default: begin
        reversed = !reversed;
        queue_result(record, 1'b1, 8'h00, 1'b1);
      end
    endcase
  endtask

  // a copy may only read string positions that were written at some point
  function automatic bit copy_reads_written(input logic [BUF_W-1:0] bs);
    int slot;
    int lim;
    if (entry_cnt == 0) return 1'b1;
    slot = reversed ? (front_slot + entry_cnt - 1) % DEPTH : front_slot;
    lim  = buf_limit(bs);
    for (int n = 0; n < slot_len[slot] && n + 1 < lim; n++) begin
      if (!char_written[slot*MAX_LEN + n]) return 1'b0;
      if (char_mem[slot*MAX_LEN + n] == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic add_item(input mode_e m, input logic [CHAR_W-1:0] ch, input logic last,
                          input logic copy, input logic [BUF_W-1:0] bs);
    in_t op;
    op.mode     = m;
    op.in_char  = ch;
    op.in_last  = last;
    op.copy_out = copy;
    op.buf_size = bs;
    if (m == MODE_REMOVE && copy && !copy_reads_written(bs)) op.copy_out = 1'b0;
    apply_to_deque(op, 1'b0);
    deque_ops_queued.push_back(op);
  endtask

  task automatic add_byte(input mode_e side, input logic [CHAR_W-1:0] ch, input logic last);
    add_item(side, ch, last, 1'($urandom), BUF_W'($urandom));
  endtask

  task automatic add_remove(input logic copy, input logic [BUF_W-1:0] bs);
    add_item(MODE_REMOVE, CHAR_W'($urandom), 1'($urandom), copy, bs);
  endtask

  task automatic add_reverse();
    add_item(MODE_REVERSE, CHAR_W'($urandom), 1'($urandom), 1'($urandom), BUF_W'($urandom));
  endtask

  function automatic mode_e any_side();
    if ($urandom_range(1)) return MODE_INS_TAIL;
    return MODE_INS_HEAD;
  endfunction

  function automatic logic [CHAR_W-1:0] any_char();
    if ($urandom_range(15) == 0) return 8'h00;
    return CHAR_W'($urandom_range(255, 1));
  endfunction

  task automatic add_string(input mode_e side, input int len);
    for (int i = 0; i < len; i++) add_byte(side, any_char(), i == len - 1);
  endtask

  // string whose bytes go to either side at random, with removes and reverses mixed in
  task automatic add_broken_string();
    int n;
    n = $urandom_range(6, 2);
    for (int i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(3) == 0) begin
        if ($urandom_range(1)) add_remove(1'b1, BUF_W'($urandom));
        else add_reverse();
      end
      add_byte(any_side(), any_char(), i == n - 1);
    end
  endtask

  task automatic fill_deque();
    while (entry_cnt < DEPTH) add_string(any_side(), $urandom_range(3, 1));
    add_string(any_side(), 2);
    add_string(any_side(), 1);
  endtask

  task automatic build_stimulus();
    int pick;
    int len;
    add_remove(1'b1, 6'd33);
    add_reverse();
    add_byte(MODE_INS_TAIL, 8'hFF, 1'b1);
    add_byte(MODE_INS_HEAD, 8'h01, 1'b0);
    add_byte(MODE_INS_HEAD, 8'h80, 1'b1);
    add_byte(MODE_INS_TAIL, 8'h41, 1'b0);
    add_byte(MODE_INS_TAIL, 8'h00, 1'b0);
    add_byte(MODE_INS_TAIL, 8'h42, 1'b1);
    add_remove(1'b1, 6'd0);
    add_reverse();
    add_remove(1'b1, 6'd63);
    add_remove(1'b0, 6'd33);
    add_byte(MODE_INS_HEAD, 8'h7E, 1'b0);
    add_byte(MODE_INS_TAIL, 8'h81, 1'b1);
    add_byte(MODE_INS_TAIL, 8'h33, 1'b0);
    add_reverse();
    add_byte(MODE_INS_TAIL, 8'h44, 1'b1);
    add_remove(1'b1, 6'd1);
    add_remove(1'b1, 6'd2);
    add_remove(1'b1, 6'd33);
    for (int r = 0; deque_ops_queued.size() < DEPTH_ITEMS; r++) begin
      if (r % 60 == 30) fill_deque();
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(40, 30) : $urandom_range(8, 1);
        add_string(any_side(), len);
      end else if (pick < 78) begin
        add_remove($urandom_range(9) != 0,
                   $urandom_range(1) ? BUF_W'($urandom_range(10)) : BUF_W'($urandom));
      end else if (pick < 88) begin
        add_reverse();
      end else begin
        add_broken_string();
      end
    end
    ops_total = deque_ops_queued.size();
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (deque_results_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result ok=%0b char=%02h last=%0b count=%0d",
                                got.ok, got.out_char, got.out_last, got.count));
    end else begin
      want = deque_results_due.pop_front();
      if (got.ok !== want.ok)
        report_mismatch($sformatf("ok %0b, expected %0b", got.ok, want.ok));
      if (got.out_char !== want.out_char)
        report_mismatch($sformatf("out_char %02h, expected %02h", got.out_char, want.out_char));
      if (got.out_last !== want.out_last)
        report_mismatch($sformatf("out_last %0b, expected %0b", got.out_last, want.out_last));
      if (got.count !== want.count)
        report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_to_deque(in_data, 1'b1);
        ops_accepted <= ops_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (deque_ops_queued.size() != 0 &&
            (quiet_stretch || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= deque_ops_queued.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      out_stall <= !quiet_stretch && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    clear_deque();
    build_stimulus();
    clear_deque();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (ops_accepted != ops_total) @(posedge clk);
    while (deque_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
